FILE: design/tmsw_pkg.sv
// ----------------------------------------------------------------------------
// tmsw_pkg
// Shared types and constants of the text-mode screen writer: field widths,
// character codes, defaults and the controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package tmsw_pkg;

   // request and response field widths
   localparam int CHAR_W     = 9;
   localparam int TAIL_W     = 7;
   localparam int ADDR_W     = 11;
   localparam int CURSOR_W   = 11;
   localparam int CELL_W     = 16;
   localparam int ATTR_W     = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // default geometry
   localparam int DEF_COLUMNS    = 80;
   localparam int DEF_SCROLL_ROW = 24;
   localparam int DEF_CELL_DEPTH = 2048;

   // command kinds carried in tuser
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // character codes
   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 9'd10;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 9'd256;
   localparam logic [7:0]        BLANK_CHAR     = 8'h20;
   localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic rd_issue;
      logic rd_capture;
      logic start_clear;
      logic start_bs;
      logic start_ins;
      logic start_scroll;
      logic start_row_clear;
      logic write_char;
      logic write_blank;
      logic pos_newline;
      logic pos_back;
      logic pos_inc;
      logic pos_scroll;
      logic out_load;
   } tmsw_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic busy;
      logic is_read;
      logic is_newline;
      logic is_backspace;
      logic scroll_needed;
      logic out_free;
   } tmsw_sts_type;

endpackage

`default_nettype wire

FILE: design/tmsw_ram.sv
// ----------------------------------------------------------------------------
// tmsw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/tmsw_ctrl.sv
// ----------------------------------------------------------------------------
// tmsw_ctrl
// Controller state machine: sequences the clearing pass, reads, the shift
// sweeps of a put, the scroll and the trailing blank.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsw_ctrl
   import tmsw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire tmsw_sts_type sts,
   output tmsw_cmd_type      cmd
);

   typedef enum logic [12:0] {
      S_INIT      = 13'b0000000000001,
      S_INIT_WAIT = 13'b0000000000010,
      S_IDLE      = 13'b0000000000100,
      S_DECODE    = 13'b0000000001000,
      S_RD_WAIT   = 13'b0000000010000,
      S_BS_WAIT   = 13'b0000000100000,
      S_INS_WAIT  = 13'b0000001000000,
      S_CHAR      = 13'b0000010000000,
      S_CHECK     = 13'b0000100000000,
      S_SCR_WAIT  = 13'b0001000000000,
      S_ROW_WAIT  = 13'b0010000000000,
      S_BLANK     = 13'b0100000000000,
      S_DONE      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.start_clear = 1'b1;
            state_in        = S_INIT_WAIT;
         end
         S_INIT_WAIT: begin
            if (!sts.busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_read) begin
               cmd.rd_issue = 1'b1;
               state_in     = S_RD_WAIT;
            end else if (sts.is_newline) begin
               cmd.pos_newline = 1'b1;
               state_in        = S_CHECK;
            end else if (sts.is_backspace) begin
               cmd.start_bs = 1'b1;
               cmd.pos_back = 1'b1;
               state_in     = S_BS_WAIT;
            end else begin
               cmd.start_ins = 1'b1;
               state_in      = S_INS_WAIT;
            end
         end
         S_RD_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_DONE;
         end
         S_BS_WAIT: begin
            if (!sts.busy) begin
               state_in = S_CHECK;
            end
         end
         S_INS_WAIT: begin
            if (!sts.busy) begin
               state_in = S_CHAR;
            end
         end
         S_CHAR: begin
            cmd.write_char = 1'b1;
            cmd.pos_inc    = 1'b1;
            state_in       = S_CHECK;
         end
         S_CHECK: begin
            if (sts.scroll_needed) begin
               cmd.start_scroll = 1'b1;
               cmd.pos_scroll   = 1'b1;
               state_in         = S_SCR_WAIT;
            end else begin
               state_in = S_BLANK;
            end
         end
         S_SCR_WAIT: begin
            if (!sts.busy) begin
               cmd.start_row_clear = 1'b1;
               state_in            = S_ROW_WAIT;
            end
         end
         S_ROW_WAIT: begin
            if (!sts.busy) begin
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            cmd.write_blank = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/tmsw_dp.sv
// ----------------------------------------------------------------------------
// tmsw_dp
// Datapath: cell memory, cursor and column, request and response registers,
// and a sweep engine that copies or fills runs of cells one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsw_dp
   import tmsw_pkg::*;
#(
   parameter int COLUMNS    = DEF_COLUMNS,
   parameter int SCROLL_ROW = DEF_SCROLL_ROW,
   parameter int CELL_DEPTH = DEF_CELL_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request payload
   input  wire logic                  req_cmd,
   input  wire logic [CHAR_W-1:0]     req_char_code,
   input  wire logic [TAIL_W-1:0]     req_tail_len,
   input  wire logic [ADDR_W-1:0]     req_cell_addr,
   // attribute register write
   input  wire logic                  csr_valid,
   input  wire logic [ATTR_W-1:0]     csr_wdata,
   // response side
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [CURSOR_W-1:0]        rsp_position,
   output logic [CELL_W-1:0]          rsp_cell_data,
   // controller link
   input  wire tmsw_cmd_type          cmd,
   output tmsw_sts_type               sts
);

   localparam int AW      = $clog2(CELL_DEPTH);
   localparam int POS_W   = $clog2(SCROLL_ROW * COLUMNS + 1);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int SUM_W   = ((POS_W > TAIL_W) ? POS_W : TAIL_W) + 1;
   localparam int CNT_W   = $clog2(CELL_DEPTH + SCROLL_ROW * COLUMNS + 129);

   localparam logic [AW-1:0]    COL_ADDR   = AW'(COLUMNS % CELL_DEPTH);
   localparam logic [AW-1:0]    ROW_ADDR   = AW'(((SCROLL_ROW - 1) * COLUMNS) % CELL_DEPTH);
   localparam logic [CNT_W-1:0] SCROLL_CNT = CNT_W'((SCROLL_ROW - 1) * COLUMNS);
   localparam logic [CNT_W-1:0] ROW_CNT    = CNT_W'(COLUMNS);
   localparam logic [CNT_W-1:0] CLEAR_CNT  = CNT_W'(CELL_DEPTH);
   localparam logic [POS_W-1:0] END_POS    = POS_W'(SCROLL_ROW * COLUMNS);
   localparam logic [POS_W-1:0] COL_STEP   = POS_W'(COLUMNS);
   localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);

   // latched request
   logic              cmd_ff;
   logic [CHAR_W-1:0] code_ff;
   logic [TAIL_W-1:0] tail_ff;
   logic [ADDR_W-1:0] addr_ff;

   // cursor, column and attribute
   logic [POS_W-1:0]  cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ATTR_W-1:0] attr_ff;

   // sweep engine
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]     src_ff, src_in;
   logic [AW-1:0]     dst_ff, dst_in;
   logic              down_ff, down_in;
   logic              fill_ff, fill_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic              active;

   // read capture and response
   logic [CELL_W-1:0]   cell_ff;
   logic                rsp_valid_ff;
   logic [CURSOR_W-1:0] rsp_cursor_ff;
   logic [CELL_W-1:0]   rsp_cell_ff;

   // address arithmetic, wrapped to the cell depth
   logic                    cursor_nz;
   logic [POS_W-1:0]        bs_start;
   logic [SUM_W-1:0]        line_end;
   logic [POS_W+AW-1:0]     cursor_ext;
   logic [POS_W+AW-1:0]     bs_ext;
   logic [SUM_W+AW-1:0]     line_end_ext;
   logic [ADDR_W+AW-1:0]    rd_addr_ext;
   logic [POS_W+CURSOR_W-1:0] cursor_out_ext;
   logic [AW-1:0]           cursor_addr;
   logic [AW-1:0]           bs_addr;
   logic [AW-1:0]           line_end_addr;
   logic [AW-1:0]           req_addr;

   // memory ports
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   assign cursor_nz      = (cursor_ff != '0);
   assign bs_start       = cursor_nz ? (cursor_ff - POS_W'(1)) : '0;
   assign line_end       = SUM_W'(cursor_ff) + SUM_W'(tail_ff);
   assign cursor_ext     = {{AW{1'b0}}, cursor_ff};
   assign bs_ext         = {{AW{1'b0}}, bs_start};
   assign line_end_ext   = {{AW{1'b0}}, line_end};
   assign rd_addr_ext    = {{AW{1'b0}}, addr_ff};
   assign cursor_out_ext = {{CURSOR_W{1'b0}}, cursor_ff};
   assign cursor_addr    = cursor_ext[AW-1:0];
   assign bs_addr        = bs_ext[AW-1:0];
   assign line_end_addr  = line_end_ext[AW-1:0];
   assign req_addr       = rd_addr_ext[AW-1:0];

   assign active = (cnt_ff != '0);

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff  <= req_cmd;
         code_ff <= req_char_code;
         tail_ff <= req_tail_len;
         addr_ff <= req_cell_addr;
      end
   end

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_valid) begin
         attr_ff <= csr_wdata;
      end
   end

   // sweep engine and cursor next state
   always_comb begin
      cursor_in  = cursor_ff;
      col_in     = col_ff;
      cnt_in     = cnt_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      down_in    = down_ff;
      fill_in    = fill_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;

      // one cell per cycle while a run is open
      if (active) begin
         cnt_in = cnt_ff - CNT_W'(1);
         src_in = down_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
         dst_in = down_ff ? (dst_ff - AW'(1)) : (dst_ff + AW'(1));
         if (!fill_ff) begin
            wr_pend_in = 1'b1;
            wr_addr_in = dst_ff;
         end
      end

      // run setup
      if (cmd.start_clear) begin
         cnt_in  = CLEAR_CNT;
         dst_in  = '0;
         down_in = 1'b0;
         fill_in = 1'b1;
      end
      if (cmd.start_bs) begin
         cnt_in  = CNT_W'(tail_ff) + CNT_W'(cursor_nz);
         dst_in  = bs_addr;
         src_in  = bs_addr + AW'(1);
         down_in = 1'b0;
         fill_in = 1'b0;
      end
      if (cmd.start_ins) begin
         cnt_in  = CNT_W'(tail_ff);
         dst_in  = line_end_addr;
         src_in  = line_end_addr - AW'(1);
         down_in = 1'b1;
         fill_in = 1'b0;
      end
      if (cmd.start_scroll) begin
         cnt_in  = SCROLL_CNT;
         dst_in  = '0;
         src_in  = COL_ADDR;
         down_in = 1'b0;
         fill_in = 1'b0;
      end
      if (cmd.start_row_clear) begin
         cnt_in  = ROW_CNT;
         dst_in  = ROW_ADDR;
         down_in = 1'b0;
         fill_in = 1'b1;
      end

      // cursor moves
      if (cmd.pos_newline) begin
         cursor_in = cursor_ff + COL_STEP - POS_W'(col_ff);
         col_in    = '0;
      end
      if (cmd.pos_back && cursor_nz) begin
         cursor_in = cursor_ff - POS_W'(1);
         col_in    = (col_ff == '0) ? LAST_COL : (col_ff - COL_W'(1));
      end
      if (cmd.pos_inc) begin
         cursor_in = cursor_ff + POS_W'(1);
         col_in    = (col_ff == LAST_COL) ? '0 : (col_ff + COL_W'(1));
      end
      if (cmd.pos_scroll) begin
         cursor_in = cursor_ff - COL_STEP;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff  <= '0;
         col_ff     <= '0;
         cnt_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         cursor_ff  <= cursor_in;
         col_ff     <= col_in;
         cnt_ff     <= cnt_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   // run address registers
   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      down_ff    <= down_in;
      fill_ff    <= fill_in;
      wr_addr_ff <= wr_addr_in;
   end

   // memory port selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = dst_ff;
      ram_wr_data = '0;
      if (wr_pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_addr_ff;
         ram_wr_data = ram_rd_data;
      end else if (active && fill_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = dst_ff;
      end else if (cmd.write_char) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cursor_addr;
         ram_wr_data = {attr_ff, code_ff[7:0]};
      end else if (cmd.write_blank) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = line_end_addr;
         ram_wr_data = {attr_ff, BLANK_CHAR};
      end
   end

   assign ram_rd_en   = (active && !fill_ff) || cmd.rd_issue;
   assign ram_rd_addr = (active && !fill_ff) ? src_ff : req_addr;

   tmsw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // read capture
   always_ff @(posedge clock) begin
      if (cmd.rd_capture) begin
         cell_ff <= ram_rd_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_cursor_ff <= cursor_out_ext[CURSOR_W-1:0];
         rsp_cell_ff   <= (cmd_ff == CMD_READ) ? cell_ff : '0;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_position   = rsp_cursor_ff;
   assign rsp_cell_data  = rsp_cell_ff;

   // status
   assign sts.busy          = active || wr_pend_ff;
   assign sts.is_read       = (cmd_ff == CMD_READ);
   assign sts.is_newline    = (code_ff == CODE_NEWLINE);
   assign sts.is_backspace  = (code_ff == CODE_BACKSPACE);
   assign sts.scroll_needed = (cursor_ff >= END_POS);
   assign sts.out_free      = !rsp_valid_ff || rsp_tready;

   // a run is only opened on an idle sweep engine
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_clear || cmd.start_bs || cmd.start_ins || cmd.start_scroll ||
       cmd.start_row_clear) |-> !(active || wr_pend_ff))
      else $error("sweep started while busy");

   // single cell writes never collide with a sweep
   a_single_write_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_char || cmd.write_blank) |-> !(active || wr_pend_ff))
      else $error("cell write during sweep");

   // a copy write never overlaps a fill
   a_no_fill_overlap: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !(active && fill_ff))
      else $error("copy write overlaps fill");

   // cursor is back in the visible rows when a put completes
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (cursor_ff < END_POS))
      else $error("cursor past scroll row");

   // column tracks the cursor inside a row
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= LAST_COL)
      else $error("column out of range");

endmodule

`default_nettype wire

FILE: design/text_mode_screen_writer_core.sv
// ----------------------------------------------------------------------------
// text_mode_screen_writer_core
// Text-mode screen writer: cell memory and cursor, put and read requests.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: char_code, tail_len, cell_addr
//                                        tuser: cmd
//   rsp      out  rsp_tvalid/rsp_tready  tdata: position, cell_data
//   csr      in   csr_valid/csr_ready    csr_wdata: char_attribute
//
// A character or a backspace shifts the tail_len cells behind the cursor, and a
// put that scrolls also copies (SCROLL_ROW-1)*COLUMNS cells up and clears a row of
// COLUMNS cells. The single-port-per-direction cell memory moves one cell
// a cycle. After reset a clearing pass over all CELL_DEPTH cells runs before
// the first request is taken; attribute writes are taken at any time.
// A response waits in its output register while the next request is taken.
// CELL_DEPTH is a power of two: cell indexes wrap by truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_screen_writer_core
   import tmsw_pkg::*;
#(
   parameter int COLUMNS    = DEF_COLUMNS,
   parameter int SCROLL_ROW = DEF_SCROLL_ROW,
   parameter int CELL_DEPTH = DEF_CELL_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // char_code[8:0], tail_len[15:9],
                                                   // cell_addr[26:16], zero above
   input  wire logic [0:0]            req_tuser,   // cmd[0]
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // position[10:0], cell_data[26:11],
                                                   // zero above
   // attribute register write
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [ATTR_W-1:0]     csr_wdata
);

   localparam int RSP_USED_W = CURSOR_W + CELL_W;

   tmsw_cmd_type        cmd;
   tmsw_sts_type        sts;
   logic [CURSOR_W-1:0] rsp_position;
   logic [CELL_W-1:0]   rsp_cell_data;

   assign csr_ready = 1'b1;

   // controller
   tmsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   tmsw_dp #(
      .COLUMNS    (COLUMNS),
      .SCROLL_ROW (SCROLL_ROW),
      .CELL_DEPTH (CELL_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_tuser[0]),
      .req_char_code  (req_tdata[CHAR_W-1:0]),
      .req_tail_len   (req_tdata[CHAR_W+TAIL_W-1:CHAR_W]),
      .req_cell_addr  (req_tdata[CHAR_W+TAIL_W+ADDR_W-1:CHAR_W+TAIL_W]),
      .csr_valid      (csr_valid),
      .csr_wdata      (csr_wdata),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_position   (rsp_position),
      .rsp_cell_data  (rsp_cell_data),
      .cmd            (cmd),
      .sts            (sts)
   );

   // response packing
   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}}, rsp_cell_data, rsp_position};

endmodule

`default_nettype wire
